@@ hw/rtl/tpi_pkg.sv @@
// shared types, constants and register indexes for the tile picking block
`default_nettype none

package tpi_pkg;

    localparam int COORD_BITS    = 24;
    localparam int MAX_COUNT_DEF = 1024;
    localparam int SIZE_W        = 16;
    localparam int CNT_W         = 11;
    localparam int COL_W         = 10;
    localparam int IDX_W         = 20;
    localparam int CFG_IDX_W     = 3;
    localparam int PROD_W        = 2 * SIZE_W;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_X     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_Y     = 3'd6;

    localparam logic MODE_RECT = 1'b0;
    localparam logic MODE_ISO  = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
    } in_item_t;

    typedef struct packed {
        logic             hit;
        logic [COL_W-1:0] tile_col;
        logic [COL_W-1:0] tile_row;
        logic [IDX_W-1:0] tile_index;
    } out_item_t;

    // live map settings, counts already clamped
    typedef struct packed {
        logic              shape_mode;
        logic [SIZE_W-1:0] tile_width;
        logic [SIZE_W-1:0] tile_height;
        logic [CNT_W-1:0]  count_x;
        logic [CNT_W-1:0]  count_y;
    } map_cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/tpi_divider.sv @@
// pipelined restoring divider, one quotient bit per register stage
`default_nettype none

module tpi_divider #(
    parameter int NUM_W = 24
) (
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic [NUM_W-1:0]          num,
    input  wire logic [tpi_pkg::SIZE_W-1:0] den,
    output logic      [NUM_W-1:0]          quot,
    output logic      [tpi_pkg::SIZE_W-1:0] rem
);
    import tpi_pkg::*;

    logic [NUM_W-1:0]  num_reg  [NUM_W];
    logic [NUM_W-1:0]  quot_reg [NUM_W];
    logic [SIZE_W-1:0] rem_reg  [NUM_W];

    logic [NUM_W-1:0]  num_next  [NUM_W];
    logic [NUM_W-1:0]  quot_next [NUM_W];
    logic [SIZE_W-1:0] rem_next  [NUM_W];

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++)
        begin : g_stage
            logic [NUM_W-1:0]  num_in;
            logic [NUM_W-1:0]  quot_in;
            logic [SIZE_W-1:0] rem_in;
            logic [SIZE_W:0]   trial;
            logic [SIZE_W:0]   diff;
            logic              ge;

            if (k == 0)
            begin : g_first
                assign num_in  = num;
                assign quot_in = '0;
                assign rem_in  = '0;
            end
            else
            begin : g_rest
                assign num_in  = num_reg[k-1];
                assign quot_in = quot_reg[k-1];
                assign rem_in  = rem_reg[k-1];
            end

            always_comb
            begin
                trial        = {rem_in, num_in[NUM_W-1]};
                diff         = trial - {1'b0, den};
                ge           = (trial >= {1'b0, den});
                rem_next[k]  = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
                num_next[k]  = num_in << 1;
                quot_next[k] = {quot_in[NUM_W-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[k]  <= num_next[k];
                    quot_reg[k] <= quot_next[k];
                    rem_reg[k]  <= rem_next[k];
                end
            end
        end
    endgenerate

    assign quot = quot_reg[NUM_W-1];
    assign rem  = rem_reg[NUM_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/tpi_tile_select.sv @@
// triangle tests, bounds checks and index build after the division
`default_nettype none

module tpi_tile_select (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire tpi_pkg::map_cfg_t             cfg,
    input  wire logic                          in_valid,
    input  wire logic                          pre_miss,
    input  wire logic [tpi_pkg::COORD_BITS-1:0] ix,
    input  wire logic [tpi_pkg::COORD_BITS-1:0] iy,
    input  wire logic [tpi_pkg::SIZE_W-1:0]    rx,
    input  wire logic [tpi_pkg::SIZE_W-1:0]    ry,
    output logic                               out_valid,
    output tpi_pkg::out_item_t                 out_item
);
    import tpi_pkg::*;

    localparam int CMP_W = COORD_BITS + 2;
    localparam int SUM_W = PROD_W + 3;

    typedef struct packed {
        logic low;
        logic high;
        logic ix0;
        logic iy0;
        logic iy_gt_half;
        logic iy_ge_half;
        logic odd_over;
        logic ix_lt_cx;
        logic ix_le_cx;
        logic iy_lt_cy;
        logic rx2_ge;
    } flags_t;

    // multiply stage
    logic              vm_reg;
    logic              miss_m_reg;
    logic [PROD_W-1:0] ryw_reg;
    logic [PROD_W-1:0] rxh_reg;
    logic [PROD_W-1:0] tt_reg;
    flags_t            flags_reg;
    flags_t            flags_next;
    logic [CNT_W-1:0]  ix_m_reg;
    logic [CNT_W-1:0]  iy_m_reg;

    logic [CMP_W-1:0] ix_w;
    logic [CMP_W-1:0] iy_w;
    logic [CMP_W-1:0] cx_w;
    logic [CMP_W-1:0] cy_w;
    logic [CMP_W-1:0] half_w;

    always_comb
    begin
        ix_w   = CMP_W'(ix);
        iy_w   = CMP_W'(iy);
        cx_w   = CMP_W'(cfg.count_x);
        cy_w   = CMP_W'(cfg.count_y);
        half_w = CMP_W'(cfg.count_y >> 1);

        flags_next.low        = ({ry, 1'b0} < {1'b0, cfg.tile_height});
        flags_next.high       = ({ry, 1'b0} > {1'b0, cfg.tile_height});
        flags_next.ix0        = (ix == '0);
        flags_next.iy0        = (iy == '0);
        flags_next.iy_gt_half = (iy_w > half_w);
        flags_next.iy_ge_half = (iy_w >= half_w);
        flags_next.odd_over   = ({iy_w[CMP_W-2:0], 1'b1} >= cy_w);
        flags_next.ix_lt_cx   = (ix_w < cx_w);
        flags_next.ix_le_cx   = (ix_w <= cx_w);
        flags_next.iy_lt_cy   = (iy_w < cy_w);
        flags_next.rx2_ge     = ({rx, 1'b0} >= {1'b0, cfg.tile_width});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            miss_m_reg <= pre_miss;
            ryw_reg    <= ry * cfg.tile_width;
            rxh_reg    <= rx * cfg.tile_height;
            tt_reg     <= cfg.tile_width * cfg.tile_height;
            flags_reg  <= flags_next;
            ix_m_reg   <= ix[CNT_W-1:0];
            iy_m_reg   <= iy[CNT_W-1:0];
        end
    end

    // decision stage
    logic             vd_reg;
    logic             hit_d_reg;
    logic [CNT_W-1:0] row_d_reg;
    logic [CNT_W-1:0] col_d_reg;
    logic             hit_d_next;
    logic [CNT_W-1:0] row_d_next;
    logic [CNT_W-1:0] col_d_next;

    logic [SUM_W-1:0] a_s;
    logic [SUM_W-1:0] b_s;
    logic [SUM_W-1:0] t_s;
    logic             t_ll;
    logic             t_lr;
    logic             t_ul;
    logic             t_ur;
    logic             iso_ok;
    logic             odd;
    logic [CNT_W:0]   iy2;
    logic [CNT_W-1:0] iso_row;

    always_comb
    begin
        a_s  = {2'b00, ryw_reg, 1'b0};
        b_s  = {2'b00, rxh_reg, 1'b0};
        t_s  = SUM_W'(tt_reg);
        t_ll = flags_reg.low && ((a_s + b_s) < t_s);
        t_lr = flags_reg.low && !t_ll && ((a_s + t_s) < b_s);
        t_ul = flags_reg.high && (a_s > (b_s + t_s));
        t_ur = flags_reg.high && !t_ul && ((a_s + b_s) > (t_s + {t_s[SUM_W-2:0], 1'b0}));
        iy2  = {1'b0, iy_m_reg} << 1;

        iso_ok  = 1'b0;
        iso_row = '0;
        odd     = 1'b0;
        priority if (t_ll)
        begin
            iso_ok  = !flags_reg.iy0 && !flags_reg.ix0 && !flags_reg.iy_gt_half;
            iso_row = CNT_W'(iy2 - 1'b1);
            odd     = 1'b1;
        end
        else if (t_lr)
        begin
            iso_ok  = !flags_reg.iy0 && !flags_reg.iy_gt_half;
            iso_row = CNT_W'(iy2 - 1'b1);
            odd     = 1'b1;
        end
        else if (t_ul)
        begin
            iso_ok  = !flags_reg.ix0 && !flags_reg.odd_over && !flags_reg.iy_ge_half;
            iso_row = CNT_W'(iy2 + 1'b1);
            odd     = 1'b1;
        end
        else if (t_ur)
        begin
            iso_ok  = flags_reg.ix_lt_cx && !flags_reg.odd_over && !flags_reg.iy_ge_half;
            iso_row = CNT_W'(iy2 + 1'b1);
            odd     = 1'b1;
        end
        else
        begin
            iso_ok  = !flags_reg.iy_ge_half;
            iso_row = CNT_W'(iy2);
            odd     = 1'b0;
        end

        if (cfg.shape_mode == MODE_RECT)
        begin
            hit_d_next = !miss_m_reg && flags_reg.ix_lt_cx && flags_reg.iy_lt_cy;
            row_d_next = iy_m_reg;
            col_d_next = ix_m_reg;
        end
        else if (!odd)
        begin
            hit_d_next = !miss_m_reg && iso_ok && flags_reg.ix_lt_cx;
            row_d_next = iso_row;
            col_d_next = ix_m_reg;
        end
        else if (flags_reg.rx2_ge)
        begin
            hit_d_next = !miss_m_reg && iso_ok && flags_reg.ix_lt_cx;
            row_d_next = iso_row;
            col_d_next = ix_m_reg;
        end
        else
        begin
            // left of the half-tile shift: column one to the left
            hit_d_next = !miss_m_reg && iso_ok && !flags_reg.ix0 && flags_reg.ix_le_cx;
            row_d_next = iso_row;
            col_d_next = ix_m_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
        end
        else if (en)
        begin
            vd_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_d_reg <= hit_d_next;
            row_d_reg <= row_d_next;
            col_d_reg <= col_d_next;
        end
    end

    // index stage, also the output register
    logic               vi_reg;
    out_item_t          item_reg;
    out_item_t          item_next;
    logic [2*CNT_W:0]   idx_full;

    always_comb
    begin
        idx_full = (2*CNT_W+1)'(row_d_reg) * (2*CNT_W+1)'(cfg.count_x)
                 + (2*CNT_W+1)'(col_d_reg);
        item_next = '0;
        if (hit_d_reg)
        begin
            item_next.hit        = 1'b1;
            item_next.tile_col   = col_d_reg[COL_W-1:0];
            item_next.tile_row   = row_d_reg[COL_W-1:0];
            item_next.tile_index = idx_full[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vi_reg <= 1'b0;
        end
        else if (en)
        begin
            vi_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = vi_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tile_position_to_index.sv @@
// top level of the tile picking block
//
// maps one world position (1/16 pixel) to a tile of a rectangular or staggered
// isometric map and returns hit, column, row and row*count_x+column. one beat
// is taken per clock while the output does not stall, and results leave in
// order; the divider resolves one quotient bit per register stage. stall on
// the output freezes the whole pipeline, so in_stall follows out_stall while
// a result is held. write the configuration registers only while no beat is
// in flight.
`default_nettype none

module tile_position_to_index #(
    parameter int MAX_COUNT = tpi_pkg::MAX_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire tpi_pkg::in_item_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output tpi_pkg::out_item_t                 out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tpi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tpi_pkg::COORD_BITS-1:0] cfg_data
);
    import tpi_pkg::*;

    localparam int                CAP       = (MAX_COUNT > 2047) ? 2047 : MAX_COUNT;
    localparam logic [CNT_W-1:0]  MAX_CNT_V = CNT_W'(CAP);
    localparam int                EXT_W     = 30;
    localparam int                CMP_W     = 40;

    // configuration registers
    logic                         shape_mode_reg;
    logic signed [COORD_BITS-1:0] origin_x_reg;
    logic signed [COORD_BITS-1:0] origin_y_reg;
    logic [SIZE_W-1:0]            tile_width_reg;
    logic [SIZE_W-1:0]            tile_height_reg;
    logic [CNT_W-1:0]             count_x_reg;
    logic [CNT_W-1:0]             count_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_mode_reg  <= MODE_RECT;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            tile_width_reg  <= SIZE_W'(1024);
            tile_height_reg <= SIZE_W'(512);
            count_x_reg     <= CNT_W'(64);
            count_y_reg     <= CNT_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SHAPE_MODE:  shape_mode_reg  <= cfg_data[0];
                REG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                REG_ORIGIN_Y:    origin_y_reg    <= cfg_data;
                REG_TILE_WIDTH:  tile_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_TILE_HEIGHT: tile_height_reg <= cfg_data[SIZE_W-1:0];
                REG_COUNT_X:     count_x_reg     <= cfg_data[CNT_W-1:0];
                REG_COUNT_Y:     count_y_reg     <= cfg_data[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // clamped counts, with the shape and tile sizes, feed the extent, miss checks and select stages
    map_cfg_t cfg;

    always_comb
    begin
        cfg.shape_mode  = shape_mode_reg;
        cfg.tile_width  = tile_width_reg;
        cfg.tile_height = tile_height_reg;
        cfg.count_x     = (count_x_reg > MAX_CNT_V) ? MAX_CNT_V : count_x_reg;
        cfg.count_y     = (count_y_reg > MAX_CNT_V) ? MAX_CNT_V : count_y_reg;
    end

    // isometric map extent in doubled units, refreshed from the settings
    logic [EXT_W-1:0] ext_x_reg;
    logic [EXT_W-1:0] ext_y_reg;

    always_ff @(posedge clk)
    begin
        ext_x_reg <= {(EXT_W-1)'(cfg.tile_width) * (EXT_W-1)'(cfg.count_x), 1'b0}
                   + EXT_W'(cfg.tile_width);
        ext_y_reg <= EXT_W'(cfg.tile_height) * (EXT_W'(cfg.count_y) + EXT_W'(1));
    end

    // the whole pipeline moves whenever the output register can take a beat
    logic adv;

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // offset stage
    logic                       va_reg;
    logic signed [COORD_BITS:0] dx_reg;
    logic signed [COORD_BITS:0] dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg <= (COORD_BITS+1)'(in_data.pos_x) - (COORD_BITS+1)'(origin_x_reg);
            dy_reg <= (COORD_BITS+1)'(in_data.pos_y) - (COORD_BITS+1)'(origin_y_reg);
        end
    end

    // early misses: negative offset, zero tile size or empty map, outside the diamond extent (isometric mode only)
    logic pre_miss;
    logic neg;
    logic size_zero;
    logic ext_miss;

    always_comb
    begin
        neg       = dx_reg[COORD_BITS] || dy_reg[COORD_BITS];
        size_zero = (cfg.tile_width == '0) || (cfg.tile_height == '0)
                 || (cfg.count_x == '0) || (cfg.count_y == '0);
        ext_miss  = (CMP_W'({dx_reg[COORD_BITS-1:0], 1'b0}) > CMP_W'(ext_x_reg))
                 || (CMP_W'({dy_reg[COORD_BITS-1:0], 1'b0}) > CMP_W'(ext_y_reg));
        pre_miss  = neg || size_zero || ((cfg.shape_mode == MODE_ISO) && ext_miss);
    end

    // valid and miss ride alongside the divider stages
    logic sb_valid_reg [COORD_BITS];
    logic sb_miss_reg  [COORD_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COORD_BITS; i++)
            begin
                sb_valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            sb_valid_reg[0] <= va_reg;
            for (int i = 1; i < COORD_BITS; i++)
            begin
                sb_valid_reg[i] <= sb_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_miss_reg[0] <= pre_miss;
            for (int i = 1; i < COORD_BITS; i++)
            begin
                sb_miss_reg[i] <= sb_miss_reg[i-1];
            end
        end
    end

    // cell indexes and in-cell remainders
    logic [COORD_BITS-1:0] ix;
    logic [COORD_BITS-1:0] iy;
    logic [SIZE_W-1:0]     rx;
    logic [SIZE_W-1:0]     ry;

    tpi_divider #(
        .NUM_W (COORD_BITS)
    ) u_div_x (
        .clk   (clk),
        .en    (adv),
        .num   (dx_reg[COORD_BITS-1:0]),
        .den   (cfg.tile_width),
        .quot  (ix),
        .rem   (rx)
    );

    tpi_divider #(
        .NUM_W (COORD_BITS)
    ) u_div_y (
        .clk   (clk),
        .en    (adv),
        .num   (dy_reg[COORD_BITS-1:0]),
        .den   (cfg.tile_height),
        .quot  (iy),
        .rem   (ry)
    );

    // triangle tests, bounds and index; its last stage is the output register
    tpi_tile_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .cfg       (cfg),
        .in_valid  (sb_valid_reg[COORD_BITS-1]),
        .pre_miss  (sb_miss_reg[COORD_BITS-1]),
        .ix        (ix),
        .iy        (iy),
        .rx        (rx),
        .ry        (ry),
        .out_valid (out_valid),
        .out_item  (out_data)
    );

endmodule

`default_nettype wire
